// File: src/sahc_pkg.sv
// shared widths, register codes and fixed-point constants for the sonar altitude hold controller
package sahc_pkg;

    // field widths
    localparam int RAW_W      = 16;
    localparam int DIST_W     = 19;
    localparam int SPD_W      = 24;
    localparam int THR_W      = 32;
    localparam int PILOT_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int DELTA_W    = 10;
    localparam int ALT_W      = 19;
    localparam int SPDLIM_W   = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // largest distance a range sample can give, Q3.16 metres
    localparam logic [DIST_W-1:0] DIST_MAX = 19'd429490;

    // throttle is Q24.8
    localparam int THR_FRAC = 8;
    localparam logic signed [THR_W-1:0] THR_RST = -32'sd128000;

    // range in 0.1 mm to Q3.16 m: round(raw * 4096 / 625)
    localparam int RANGE_SHIFT    = 12;
    localparam int RANGE_NUM_W    = RAW_W + RANGE_SHIFT;
    localparam int RANGE_HALF     = 312;
    localparam int RANGE_RECIP_W  = 29;
    localparam int RANGE_RECIP_SH = 38;
    localparam logic [RANGE_RECIP_W-1:0] RANGE_RECIP = 29'd439804652;

    // speed: round(|diff| * 50 / 3), the division done by reciprocal
    localparam int DIV3_W       = 25;
    localparam int DIV3_RECIP_W = 26;
    localparam int DIV3_SH      = 27;
    localparam logic [DIV3_RECIP_W-1:0] DIV3_RECIP = 26'd44739243;

    // pd term: Q16.16 times Q8.8, rounded back to Q24.8
    localparam int PD_W    = 42;
    localparam int PD_FRAC = 16;
    localparam int PD_HALF = 32768;

    // register reset values
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 16'd25600;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = 16'd0;
    localparam logic [DELTA_W-1:0]  MAX_DELTA_RST   = 10'd500;
    localparam logic [ALT_W-1:0]    ALT_MAX_RST     = 19'd183501;
    localparam logic [ALT_W-1:0]    ERR_LIMIT_RST   = 19'd65536;
    localparam logic [SPDLIM_W-1:0] SPD_CLAMP_RST   = 23'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_DERIV_GAIN  = 3'd1,
        REG_MAX_DELTA   = 3'd2,
        REG_ALT_MAX     = 3'd3,
        REG_ERR_LIMIT   = 3'd4,
        REG_SPD_CLAMP   = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        FUNC_SONAR   = 1'b0,
        FUNC_CONTROL = 1'b1
    } func_t;

    typedef enum logic {
        MODE_LOCK = 1'b0,
        MODE_HOLD = 1'b1
    } hold_mode_t;

endpackage

// File: src/sonar_altitude_hold_controller.sv
// sonar altitude hold: range conversion, weighted moving average filters and pd throttle
// registered pipeline stages: range conversion, distance filter loop, speed filter
//   with pd correction, then the result register
// throughput: one item per cycle; a waiting result stalls the stages behind it only when full
// reset: synchronous, active low; registers to their reset values, filter windows and sums
//   cleared, locked and last throttle set to -500, pipeline emptied
module sonar_altitude_hold_controller #(
    parameter int WINDOW_LENGTH = 5
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic [sahc_pkg::RAW_W-1:0]            s_range_raw,
    input  logic                                  s_hold_mode,
    input  logic signed [sahc_pkg::PILOT_W-1:0]   s_pilot_throttle,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [sahc_pkg::DIST_W-1:0]           m_filtered_distance,
    output logic signed [sahc_pkg::SPD_W-1:0]     m_filtered_speed,
    output logic signed [sahc_pkg::THR_W-1:0]     m_throttle_command,
    output logic                                  m_hold_applied,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sahc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sahc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sahc_pkg::*;

    localparam int TOTAL    = WINDOW_LENGTH * (WINDOW_LENGTH + 1) / 2;
    localparam int TOT_LOG  = $clog2(TOTAL);
    localparam int HALF     = TOTAL / 2;
    localparam int CNT_LOG  = $clog2(WINDOW_LENGTH + 1);
    localparam int DSUM_W   = DIST_W + TOT_LOG;
    localparam int DPSUM_W  = DIST_W + CNT_LOG;
    localparam int DDIV_SH  = DSUM_W + TOT_LOG;
    localparam int SSUM_W   = SPD_W + TOT_LOG;
    localparam int SPSUM_W  = SPD_W + CNT_LOG;
    localparam int SDIV_SH  = SSUM_W + TOT_LOG;
    localparam logic [63:0] DDIV_RECIP =
        ((64'd1 << DDIV_SH) + 64'(TOTAL) - 64'd1) / 64'(TOTAL);
    localparam logic [63:0] SDIV_RECIP =
        ((64'd1 << SDIV_SH) + 64'(TOTAL) - 64'd1) / 64'(TOTAL);
    localparam int DLIM_W = DELTA_W + THR_FRAC;

    // configuration registers
    logic [GAIN_W-1:0]   prop_reg;
    logic [GAIN_W-1:0]   deriv_reg;
    logic [DELTA_W-1:0]  max_delta_reg;
    logic [ALT_W-1:0]    alt_max_reg;
    logic [ALT_W-1:0]    err_lim_reg;
    logic [SPDLIM_W-1:0] spd_lim_reg;

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic out_free, ready1, ready2, ready3;
    logic in_fire, a_fire, b_fire, c_fire;

    // stage payloads
    func_t                     func1_reg, func2_reg, func3_reg;
    hold_mode_t                mode1_reg, mode2_reg, mode3_reg;
    logic signed [PILOT_W-1:0] pilot1_reg, pilot2_reg, pilot3_reg;
    logic [RAW_W-1:0]          raw1_reg;
    logic [DIST_W-1:0]         dist2_reg;
    logic signed [SPD_W-1:0]   spd3_reg;

    // filter and control state
    logic [DIST_W-1:0]         dwin_reg [WINDOW_LENGTH];
    logic signed [SPD_W-1:0]   swin_reg [WINDOW_LENGTH];
    logic [DSUM_W-1:0]         dsum_reg, dsum_next;
    logic [DPSUM_W-1:0]        dpsum_reg, dpsum_next;
    logic signed [SSUM_W-1:0]  ssum_reg, ssum_next;
    logic signed [SPSUM_W-1:0] spsum_reg, spsum_next;
    logic [DIST_W-1:0]         cur_d_reg, cur_d_next;
    logic signed [SPD_W-1:0]   cur_s_reg, cur_s_next;
    logic [DIST_W-1:0]         locked_reg, locked_next;
    logic signed [THR_W-1:0]   steady_reg, steady_next;
    logic signed [THR_W-1:0]   last_reg, last_next;
    logic                      applied_next;

    // result register
    logic [DIST_W-1:0]       out_dist_reg;
    logic signed [SPD_W-1:0] out_spd_reg;
    logic signed [THR_W-1:0] out_thr_reg;
    logic                    out_applied_reg;

    // stage A signals
    logic [RANGE_NUM_W-1:0]               range_num;
    logic [RANGE_NUM_W+RANGE_RECIP_W-1:0] range_prod;
    logic [DIST_W-1:0]                    dist_a;

    // stage B signals
    logic signed [DIST_W:0]             diff;
    logic [DIST_W:0]                    diff_abs;
    logic [DIV3_W-1:0]                  spd_num;
    logic [DIV3_W+DIV3_RECIP_W-1:0]     spd_prod;
    logic [SPD_W-1:0]                   spd_q;
    logic signed [SPD_W-1:0]            spd_b;
    logic [DSUM_W-1:0]                  dnum;
    logic [2*DSUM_W:0]                  dprod;

    // stage C signals
    logic                          s_neg;
    logic [SSUM_W-1:0]             smag, snum;
    logic [2*SSUM_W:0]             sprod;
    logic [SPD_W-1:0]              sq;
    logic signed [SPD_W-1:0]       spd_avg;
    logic                          trusted;
    logic signed [DIST_W:0]        err, err_lim, err_c;
    logic signed [SPD_W-1:0]       slim, spd_c;
    logic signed [GAIN_W:0]        prop_s, deriv_s;
    logic signed [PD_W-1:0]        pd_val;
    logic                          pd_neg;
    logic [PD_W-1:0]               pd_mag, pd_round;
    logic [PD_W-PD_FRAC-1:0]       dmag;
    logic [DLIM_W-1:0]             dlim, dmag_c;
    logic signed [DLIM_W:0]        delta;
    logic signed [THR_W:0]         thr_sum;
    logic signed [THR_W-1:0]       thr_sat, pilot_thr;

    // ---------------- handshake ----------------
    assign out_free = !m_valid_reg || m_ready;
    assign ready3   = !v3_reg || out_free;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign c_fire   = v3_reg && out_free;
    assign b_fire   = v2_reg && ready3;
    assign a_fire   = v1_reg && ready2;
    assign in_fire  = s_valid && ready1;
    assign s_ready  = ready1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                v1_reg <= 1'b1;
            end else if (a_fire) begin
                v1_reg <= 1'b0;
            end
            if (a_fire) begin
                v2_reg <= 1'b1;
            end else if (b_fire) begin
                v2_reg <= 1'b0;
            end
            if (b_fire) begin
                v3_reg <= 1'b1;
            end else if (c_fire) begin
                v3_reg <= 1'b0;
            end
            if (c_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_reg      <= PROP_GAIN_RST;
            deriv_reg     <= DERIV_GAIN_RST;
            max_delta_reg <= MAX_DELTA_RST;
            alt_max_reg   <= ALT_MAX_RST;
            err_lim_reg   <= ERR_LIMIT_RST;
            spd_lim_reg   <= SPD_CLAMP_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:   prop_reg      <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:  deriv_reg     <= cfg_data[GAIN_W-1:0];
                REG_MAX_DELTA:   max_delta_reg <= cfg_data[DELTA_W-1:0];
                REG_ALT_MAX:     alt_max_reg   <= cfg_data[ALT_W-1:0];
                REG_ERR_LIMIT:   err_lim_reg   <= cfg_data[ALT_W-1:0];
                REG_SPD_CLAMP:   spd_lim_reg   <= cfg_data[SPDLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage A: range to metres ----------------
    assign range_num  = {raw1_reg, {RANGE_SHIFT{1'b0}}} + RANGE_NUM_W'(RANGE_HALF);
    assign range_prod = range_num * RANGE_RECIP;
    assign dist_a     = range_prod[RANGE_RECIP_SH +: DIST_W];

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func1_reg  <= func_t'(s_func);
            mode1_reg  <= hold_mode_t'(s_hold_mode);
            pilot1_reg <= s_pilot_throttle;
            raw1_reg   <= s_range_raw;
        end
        if (a_fire) begin
            func2_reg  <= func1_reg;
            mode2_reg  <= mode1_reg;
            pilot2_reg <= pilot1_reg;
            dist2_reg  <= dist_a;
        end
    end

    // ---------------- stage B: speed from last filtered distance, distance filter ----------------
    assign diff     = signed'({1'b0, dist2_reg}) - signed'({1'b0, cur_d_reg});
    assign diff_abs = diff[DIST_W] ? (DIST_W+1)'(-diff) : (DIST_W+1)'(diff);
    // times 50 as shifts, plus one for rounding before the divide by three
    assign spd_num  = (DIV3_W'(diff_abs[DIST_W-1:0]) << 5)
                    + (DIV3_W'(diff_abs[DIST_W-1:0]) << 4)
                    + (DIV3_W'(diff_abs[DIST_W-1:0]) << 1)
                    + DIV3_W'(1);
    assign spd_prod = spd_num * DIV3_RECIP;
    assign spd_q    = spd_prod[DIV3_SH +: SPD_W];
    assign spd_b    = diff[DIST_W] ? -signed'(spd_q) : signed'(spd_q);

    // running weighted sum: add the newest at full weight, drop one of every tap
    assign dsum_next  = dsum_reg + DSUM_W'(dist2_reg) * DSUM_W'(WINDOW_LENGTH)
                      - DSUM_W'(dpsum_reg);
    assign dpsum_next = dpsum_reg + DPSUM_W'(dist2_reg)
                      - DPSUM_W'(dwin_reg[WINDOW_LENGTH-1]);
    assign dnum       = dsum_next + DSUM_W'(HALF);
    assign dprod      = dnum * DDIV_RECIP[DSUM_W:0];
    assign cur_d_next = dprod[DDIV_SH +: DIST_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                dwin_reg[i] <= '0;
            end
            dsum_reg  <= '0;
            dpsum_reg <= '0;
            cur_d_reg <= '0;
        end else if (b_fire && func2_reg == FUNC_SONAR) begin
            for (int i = WINDOW_LENGTH - 1; i > 0; i--) begin
                dwin_reg[i] <= dwin_reg[i-1];
            end
            dwin_reg[0] <= dist2_reg;
            dsum_reg    <= dsum_next;
            dpsum_reg   <= dpsum_next;
            cur_d_reg   <= cur_d_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            func3_reg  <= func2_reg;
            mode3_reg  <= mode2_reg;
            pilot3_reg <= pilot2_reg;
            spd3_reg   <= spd_b;
        end
    end

    // ---------------- stage C: speed filter and pd correction ----------------
    assign ssum_next  = ssum_reg + SSUM_W'(spd3_reg) * SSUM_W'(WINDOW_LENGTH)
                      - SSUM_W'(spsum_reg);
    assign spsum_next = spsum_reg + SPSUM_W'(spd3_reg)
                      - SPSUM_W'(swin_reg[WINDOW_LENGTH-1]);
    assign s_neg      = ssum_next[SSUM_W-1];
    assign smag       = s_neg ? SSUM_W'(-ssum_next) : SSUM_W'(ssum_next);
    assign snum       = smag + SSUM_W'(HALF);
    assign sprod      = snum * SDIV_RECIP[SSUM_W:0];
    assign sq         = sprod[SDIV_SH +: SPD_W];
    assign spd_avg    = s_neg ? -signed'(sq) : signed'(sq);

    assign trusted = (cur_d_reg != '0) && (cur_d_reg < alt_max_reg);

    assign err     = signed'({1'b0, locked_reg}) - signed'({1'b0, cur_d_reg});
    assign err_lim = signed'({1'b0, err_lim_reg});
    assign err_c   = (err > err_lim) ? err_lim : ((err < -err_lim) ? -err_lim : err);
    assign slim    = signed'({1'b0, spd_lim_reg});
    assign spd_c   = (cur_s_reg > slim) ? slim : ((cur_s_reg < -slim) ? -slim : cur_s_reg);
    assign prop_s  = signed'({1'b0, prop_reg});
    assign deriv_s = signed'({1'b0, deriv_reg});
    assign pd_val  = PD_W'(err_c) * PD_W'(prop_s) - PD_W'(spd_c) * PD_W'(deriv_s);

    // round half away from zero on the magnitude, then clamp it
    assign pd_neg   = pd_val[PD_W-1];
    assign pd_mag   = pd_neg ? PD_W'(-pd_val) : PD_W'(pd_val);
    assign pd_round = pd_mag + PD_W'(PD_HALF);
    assign dmag     = pd_round[PD_W-1:PD_FRAC];
    assign dlim     = {max_delta_reg, {THR_FRAC{1'b0}}};
    assign dmag_c   = (dmag > (PD_W-PD_FRAC)'(dlim)) ? dlim : dmag[DLIM_W-1:0];
    assign delta    = pd_neg ? -signed'({1'b0, dmag_c}) : signed'({1'b0, dmag_c});
    assign thr_sum  = (THR_W+1)'(steady_reg) + (THR_W+1)'(delta);
    assign thr_sat  = (thr_sum[THR_W] != thr_sum[THR_W-1])
                    ? (thr_sum[THR_W] ? {1'b1, {(THR_W-1){1'b0}}} : {1'b0, {(THR_W-1){1'b1}}})
                    : thr_sum[THR_W-1:0];
    assign pilot_thr = THR_W'(signed'({pilot3_reg, {THR_FRAC{1'b0}}}));

    always_comb begin
        cur_s_next   = cur_s_reg;
        locked_next  = locked_reg;
        steady_next  = steady_reg;
        last_next    = last_reg;
        applied_next = 1'b0;
        if (func3_reg == FUNC_SONAR) begin
            cur_s_next = spd_avg;
        end else if (mode3_reg == MODE_HOLD) begin
            if (trusted) begin
                last_next    = thr_sat;
                applied_next = 1'b1;
            end
        end else begin
            locked_next = cur_d_reg;
            steady_next = pilot_thr;
            last_next   = pilot_thr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                swin_reg[i] <= '0;
            end
            ssum_reg   <= '0;
            spsum_reg  <= '0;
            cur_s_reg  <= '0;
            locked_reg <= '0;
            steady_reg <= THR_RST;
            last_reg   <= THR_RST;
        end else if (c_fire) begin
            if (func3_reg == FUNC_SONAR) begin
                for (int i = WINDOW_LENGTH - 1; i > 0; i--) begin
                    swin_reg[i] <= swin_reg[i-1];
                end
                swin_reg[0] <= spd3_reg;
                ssum_reg    <= ssum_next;
                spsum_reg   <= spsum_next;
            end
            cur_s_reg  <= cur_s_next;
            locked_reg <= locked_next;
            steady_reg <= steady_next;
            last_reg   <= last_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (c_fire) begin
            out_dist_reg    <= cur_d_reg;
            out_spd_reg     <= cur_s_next;
            out_thr_reg     <= last_next;
            out_applied_reg <= applied_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_filtered_distance = out_dist_reg;
    assign m_filtered_speed    = out_spd_reg;
    assign m_throttle_command  = out_thr_reg;
    assign m_hold_applied      = out_applied_reg;

    // ---------------- checks ----------------
    // input stalls only when every stage is full and the result is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && m_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // correction is only applied at a trusted, nonzero altitude
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_hold_applied) |-> (m_filtered_distance != '0))
        else $error("hold applied at zero altitude");

    // a control item leaving stage B leaves the filtered distance alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_fire && func2_reg == FUNC_CONTROL) |=> (cur_d_reg == $past(cur_d_reg)))
        else $error("filtered distance moved on a control item");

    // filtered distance never exceeds the largest convertible range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_filtered_distance <= DIST_MAX))
        else $error("filtered distance out of range");

endmodule

// File: sim/altitude_hold_checker.sv
// watches the item, result and register channels, predicts each result and compares it
module altitude_hold_checker #(
    parameter int WIN_LEN = 5
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic                                 s_func,
    input  logic [sahc_pkg::RAW_W-1:0]           s_range_raw,
    input  logic                                 s_hold_mode,
    input  logic signed [sahc_pkg::PILOT_W-1:0]  s_pilot_throttle,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [sahc_pkg::DIST_W-1:0]          m_filtered_distance,
    input  logic signed [sahc_pkg::SPD_W-1:0]    m_filtered_speed,
    input  logic signed [sahc_pkg::THR_W-1:0]    m_throttle_command,
    input  logic                                 m_hold_applied,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [sahc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sahc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   fail_count,
    output int                                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import sahc_pkg::*;

    localparam int REPORT_LIMIT = 10;
    // 0.1 mm per raw count, Q16.16 metres
    localparam longint RAW_PER_METRE = 10000;
    localparam longint Q16_ONE = 65536;
    // 1 / 0.06 s = 50 / 3
    localparam longint SPEED_NUM = 50;
    localparam longint SPEED_DEN = 3;
    localparam longint THR_ONE = 256;

    typedef struct packed {
        logic [DIST_W-1:0]        distance;
        logic signed [SPD_W-1:0]  speed;
        logic signed [THR_W-1:0]  throttle;
        logic                     applied;
    } reading_t;

    reading_t awaited_readings[$];
    int failures = 0;

    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   deriv_gain;
    logic [DELTA_W-1:0]  max_delta;
    logic [ALT_W-1:0]    alt_max;
    logic [ALT_W-1:0]    err_limit;
    logic [SPDLIM_W-1:0] spd_clamp;

    longint dist_taps[WIN_LEN];
    longint speed_taps[WIN_LEN];
    int     tap_index;
    longint filt_dist;
    longint filt_speed;
    longint held_height;
    longint base_throttle;
    longint throttle_out;

    function automatic longint div_nearest(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint clamp_both(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint saturate_to(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic void restore_power_on_state();
        prop_gain     = PROP_GAIN_RST;
        deriv_gain    = DERIV_GAIN_RST;
        max_delta     = MAX_DELTA_RST;
        alt_max       = ALT_MAX_RST;
        err_limit     = ERR_LIMIT_RST;
        spd_clamp     = SPD_CLAMP_RST;
        for (int i = 0; i < WIN_LEN; i++) begin
            dist_taps[i]  = 0;
            speed_taps[i] = 0;
        end
        tap_index     = 0;
        filt_dist     = 0;
        filt_speed    = 0;
        held_height   = 0;
        base_throttle = longint'(THR_RST);
        throttle_out  = longint'(THR_RST);
    endfunction

    function automatic void store_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (cfg_reg_t'(idx))
            REG_PROP_GAIN:   prop_gain   = data[GAIN_W-1:0];
            REG_DERIV_GAIN:  deriv_gain  = data[GAIN_W-1:0];
            REG_MAX_DELTA:   max_delta   = data[DELTA_W-1:0];
            REG_ALT_MAX:     alt_max     = data[ALT_W-1:0];
            REG_ERR_LIMIT:   err_limit   = data[ALT_W-1:0];
            REG_SPD_CLAMP:   spd_clamp   = data[SPDLIM_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void advance_altitude_state(input logic func,
            input logic [RAW_W-1:0] raw, input logic mode,
            input logic signed [PILOT_W-1:0] pilot, output reading_t r);
        longint new_dist, new_speed, sum_d, sum_s, total, err, spd, prod, delta;
        int pos;
        logic applied;
        applied = 1'b0;
        if (func_t'(func) == FUNC_SONAR) begin
            new_dist  = div_nearest(longint'(raw) * Q16_ONE, RAW_PER_METRE);
            new_speed = saturate_to(div_nearest((new_dist - filt_dist) * SPEED_NUM,
                                                SPEED_DEN), SPD_W);
            dist_taps[tap_index]  = new_dist;
            speed_taps[tap_index] = new_speed;
            sum_d = 0;
            sum_s = 0;
            total = 0;
            pos   = tap_index;
            // newest tap weighs WIN_LEN, oldest weighs 1
            for (int k = 0; k < WIN_LEN; k++) begin
                sum_d += dist_taps[pos] * (WIN_LEN - k);
                sum_s += speed_taps[pos] * (WIN_LEN - k);
                total += WIN_LEN - k;
                pos = (pos == 0) ? WIN_LEN - 1 : pos - 1;
            end
            tap_index  = (tap_index + 1 >= WIN_LEN) ? 0 : tap_index + 1;
            filt_dist  = div_nearest(sum_d, total);
            filt_speed = saturate_to(div_nearest(sum_s, total), SPD_W);
        end else if (hold_mode_t'(mode) == MODE_HOLD) begin
            // correction only while the sonar altitude can be trusted
            if (filt_dist > 0 && filt_dist < longint'(alt_max)) begin
                err   = clamp_both(held_height - filt_dist, longint'(err_limit));
                spd   = clamp_both(filt_speed, longint'(spd_clamp));
                prod  = err * longint'(prop_gain) - spd * longint'(deriv_gain);
                delta = clamp_both(div_nearest(prod, Q16_ONE), longint'(max_delta) * THR_ONE);
                throttle_out = saturate_to(base_throttle + delta, THR_W);
                applied = 1'b1;
            end
        end else begin
            held_height   = filt_dist;
            throttle_out  = longint'(pilot) * THR_ONE;
            base_throttle = throttle_out;
        end
        r.distance = filt_dist[DIST_W-1:0];
        r.speed    = filt_speed[SPD_W-1:0];
        r.throttle = throttle_out[THR_W-1:0];
        r.applied  = applied;
    endfunction

    function automatic void note_failure(string what, reading_t want, reading_t got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%0t %s: dist %0d/%0d speed %0d/%0d throttle %0d/%0d hold %0b/%0b",
                     $time, what, want.distance, got.distance, want.speed, got.speed,
                     want.throttle, got.throttle, want.applied, got.applied);
    endfunction

    always @(posedge aclk) begin : watch
        reading_t want;
        reading_t got;
        if (!aresetn) begin
            restore_power_on_state();
            awaited_readings.delete();
        end else begin
            if (cfg_valid && cfg_ready) store_register(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                advance_altitude_state(s_func, s_range_raw, s_hold_mode, s_pilot_throttle, want);
                awaited_readings.push_back(want);
            end
            if (m_valid && m_ready) begin
                got.distance = m_filtered_distance;
                got.speed    = m_filtered_speed;
                got.throttle = m_throttle_command;
                got.applied  = m_hold_applied;
                if (awaited_readings.size() == 0) begin
                    note_failure("result with no item pending (expected/actual)", '0, got);
                end else begin
                    want = awaited_readings.pop_front();
                    if (got.distance !== want.distance || got.speed !== want.speed ||
                        got.throttle !== want.throttle || got.applied !== want.applied)
                        note_failure("result mismatch (expected/actual)", want, got);
                end
            end
        end
        pending_count <= awaited_readings.size();
        fail_count    <= failures;
    end

endmodule

// File: sim/testbench.sv
// top of the sonar altitude hold testbench: clock, reset, stimulus, result side and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sahc_pkg::*;

    localparam int WIN_LEN          = 5;
    localparam int RESULT_LATENCY   = 3;
    localparam int SETTLE_CYCLES    = 2 * RESULT_LATENCY + 4;
    localparam int IDLE_PERCENT     = 21;
    localparam int HOLD_OFF_CYCLES  = 120;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int PHASE_COUNT      = 8;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int RESET_CYCLES     = 7;
    localparam int RAW_MAX          = 65535;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_func;
    logic [RAW_W-1:0]           s_range_raw;
    logic                       s_hold_mode;
    logic signed [PILOT_W-1:0]  s_pilot_throttle;
    logic                       m_valid;
    logic                       m_ready;
    logic [DIST_W-1:0]          m_filtered_distance;
    logic signed [SPD_W-1:0]    m_filtered_speed;
    logic signed [THR_W-1:0]    m_throttle_command;
    logic                       m_hold_applied;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    bit steady_flow = 1'b0;
    int hold_off_requests = 0;
    int hold_off_served = 0;
    int raw_level;
    int raw_ceiling;

    sonar_altitude_hold_controller #(
        .WINDOW_LENGTH(WIN_LEN)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_range_raw        (s_range_raw),
        .s_hold_mode        (s_hold_mode),
        .s_pilot_throttle   (s_pilot_throttle),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_filtered_distance(m_filtered_distance),
        .m_filtered_speed   (m_filtered_speed),
        .m_throttle_command (m_throttle_command),
        .m_hold_applied     (m_hold_applied),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    altitude_hold_checker #(
        .WIN_LEN(WIN_LEN)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_range_raw        (s_range_raw),
        .s_hold_mode        (s_hold_mode),
        .s_pilot_throttle   (s_pilot_throttle),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_filtered_distance(m_filtered_distance),
        .m_filtered_speed   (m_filtered_speed),
        .m_throttle_command (m_throttle_command),
        .m_hold_applied     (m_hold_applied),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .pending_count      (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off whenever one is asked for
    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && hold_off_served < hold_off_requests) begin
                hold_off_served += 1;
                m_ready <= 1'b0;
                for (int n = 1; n < HOLD_OFF_CYCLES; n++) @(posedge aclk);
            end else begin
                m_ready <= steady_flow || $urandom_range(99) >= IDLE_PERCENT;
            end
        end
    end

    function automatic int raw_for_altitude(int alt);
        int raw;
        raw = int'(longint'(alt) * 10000 / 65536);
        return (raw > RAW_MAX) ? RAW_MAX : raw;
    endfunction

    task automatic send_command(input func_t func, input logic [RAW_W-1:0] raw,
                                input hold_mode_t mode, input logic signed [PILOT_W-1:0] pilot);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_func           <= func;
        s_range_raw      <= raw;
        s_hold_mode      <= mode;
        s_pilot_throttle <= pilot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and let every result drain before going on
    task automatic settle_after_items();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value,
                                  input int width);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        // junk above the register width must be dropped
        cfg_data  <= (CFG_DATA_W'($urandom) << width) | CFG_DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_settings(input int prop, input int deriv, input int delta,
                                  input int alt, input int err_lim, input int spd_lim,
                                  input bit spares);
        write_register(REG_PROP_GAIN, prop, GAIN_W);
        write_register(REG_DERIV_GAIN, deriv, GAIN_W);
        write_register(REG_MAX_DELTA, delta, DELTA_W);
        write_register(REG_ALT_MAX, alt, ALT_W);
        write_register(REG_ERR_LIMIT, err_lim, ALT_W);
        write_register(REG_SPD_CLAMP, spd_lim, SPDLIM_W);
        if (spares) begin
            write_register(REG_SPARE_LO, 0, 0);
            write_register(REG_SPARE_HI, 0, 0);
        end
        cfg_valid <= 1'b0;
        raw_ceiling = raw_for_altitude(alt);
        raw_level   = raw_ceiling / 2;
    endtask

    task automatic choose_settings(input int phase);
        case (phase)
            1: apply_settings(65535, 65535, 1023, 429490, 429490, 8388607, 1'b1);
            2: apply_settings(0, 0, 0, 0, 0, 0, 1'b0);
            3: apply_settings(65535, 0, 1023, 429490, 429490, 65536, 1'b0);
            default: apply_settings($urandom_range(65535), $urandom_range(65535),
                                    $urandom_range(1023), $urandom_range(429490, 65536),
                                    $urandom_range(429490),
                                    ($urandom_range(1)) ? $urandom_range(1 << 18)
                                                        : $urandom_range(8388607),
                                    phase == 5);
        endcase
    endtask

    task automatic run_directed();
        send_command(FUNC_CONTROL, 16'hffff, MODE_HOLD, 16'sh7fff);  // nothing measured yet
        send_command(FUNC_CONTROL, 16'h0000, MODE_LOCK, 16'sh8000);
        send_command(FUNC_SONAR, 16'h0000, MODE_HOLD, 16'sh0000);
        repeat (2) send_command(FUNC_SONAR, 16'hffff, MODE_LOCK, -16'sd1);
        send_command(FUNC_CONTROL, 16'h0000, MODE_HOLD, 16'sh0000);  // above trusted range
        send_command(FUNC_CONTROL, 16'hffff, MODE_LOCK, 16'sh7fff);
        repeat (5) send_command(FUNC_SONAR, 16'd10000, MODE_HOLD, 16'sh0000);
        send_command(FUNC_CONTROL, 16'h0000, MODE_HOLD, 16'sh0000);  // error clamped
        // settles exactly on the trusted limit
        repeat (5) send_command(FUNC_SONAR, 16'd28000, MODE_LOCK, 16'sh0000);
        send_command(FUNC_CONTROL, 16'h0000, MODE_HOLD, 16'sh0000);
        send_command(FUNC_SONAR, 16'd27990, MODE_LOCK, 16'sh0000);
        send_command(FUNC_CONTROL, 16'h0000, MODE_HOLD, 16'sh0000);
        send_command(FUNC_CONTROL, 16'h0000, MODE_LOCK, 16'sh0000);
        send_command(FUNC_CONTROL, 16'h0000, MODE_HOLD, 16'sh0000);
        send_command(FUNC_SONAR, 16'h0001, MODE_HOLD, 16'sh0000);
        send_command(FUNC_CONTROL, 16'h0000, MODE_LOCK, -16'sd1);
    endtask

    // mostly a wandering altitude with locks and holds, some noise
    task automatic send_random_item();
        int pick;
        int step;
        int p;
        logic [RAW_W-1:0] raw;
        logic signed [PILOT_W-1:0] pilot;
        pick  = $urandom_range(99);
        raw   = RAW_W'($urandom);
        pilot = PILOT_W'($urandom);
        if (pick < 8) begin
            send_command(func_t'($urandom_range(1)), raw, hold_mode_t'($urandom_range(1)), pilot);
        end else if (pick < 58) begin
            if ($urandom_range(19) == 0) begin
                raw_level = ($urandom_range(3) == 0) ? $urandom_range(RAW_MAX)
                                                     : $urandom_range(raw_ceiling);
            end else begin
                step = $urandom_range(800);
                raw_level = raw_level + step - 400;
                if (raw_level < 0) raw_level = 0;
                if (raw_level > RAW_MAX) raw_level = RAW_MAX;
            end
            send_command(FUNC_SONAR, RAW_W'(raw_level), hold_mode_t'($urandom_range(1)), pilot);
        end else if (pick < 86) begin
            send_command(FUNC_CONTROL, raw, MODE_HOLD, pilot);
        end else begin
            if ($urandom_range(1)) begin
                p = $urandom_range(800);
                pilot = PILOT_W'(p - 400);
            end
            send_command(FUNC_CONTROL, raw, MODE_LOCK, pilot);
        end
    endtask

    initial begin : stimulus
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_func           = FUNC_SONAR;
        s_range_raw      = '0;
        s_hold_mode      = MODE_LOCK;
        s_pilot_throttle = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        raw_ceiling      = raw_for_altitude(int'(ALT_MAX_RST));
        raw_level        = raw_ceiling / 2;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 0) begin
                run_directed();
            end else begin
                settle_after_items();
                choose_settings(phase);
            end
            steady_flow = (phase == 2);
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                // long result stall while items keep coming, so the block backs up
                if (k == RANDOM_PER_PHASE / 3 && phase != 2) hold_off_requests += 1;
                if (k == 2 * RANDOM_PER_PHASE / 3) settle_after_items();
                send_random_item();
            end
        end
        steady_flow = 1'b0;
        settle_after_items();
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
